>>> sv/imu_cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_cal_pkg
// Shared widths, register indexes and controller/datapath handshake types
// for the IMU bias calibration block.
// ----------------------------------------------------------------------------
package imu_cal_pkg;

    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned MEAN_Z_W      = 17;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned NUM_LANES     = 6;   // acc x/y/z then rate x/y/z
    localparam int unsigned LANE_W        = 3;
    localparam int unsigned MAX_PACKETS_DEF = 64;
    localparam int unsigned GRAVITY_MAX   = 32768;
    localparam int unsigned GRAVITY_RESET = 16384;

    localparam logic [CFG_IDX_W-1:0] REG_TRIM_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd3;

    localparam logic [LANE_W-1:0] LANE_FIRST = 3'd0;
    localparam logic [LANE_W-1:0] LANE_LAST  = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic              in_ready;
        logic              div_start;
        logic              div_store;
        logic              finish;
        logic [LANE_W-1:0] lane;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> sv/imu_bias_calibration.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_calibration
// Averages accelerometer and gyro packets over a run and emits the bias
// means, gyro offset words and accelerometer trim words on the final packet.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  s_*       s_valid / s_ready    six 16-bit samples, final_packet
//  m_*       m_valid / m_ready    six means, three gyro words, three accel words
//  cfg_*     cfg_wr_en            cfg_index, cfg_data (trims, gravity)
//
//  Non-final beats are taken back to back while idle. A final beat runs the
//  one-bit-per-cycle divider, shared by the six axes, over each axis sum of
//  SUM_W = 16 + log2(MAX_PACKETS) bits, 22 by default.
//  A beat may be taken while a result waits on m_ready; the run ends only
//  when the result register is free. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module imu_bias_calibration #(
    parameter int unsigned MAX_PACKETS = imu_cal_pkg::MAX_PACKETS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  logic [imu_cal_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [imu_cal_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_acc_x,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_acc_y,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_acc_z,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_rate_x,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_rate_y,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_rate_z,
    input  logic                                      s_final_packet,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_acc_x,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_acc_y,
    output logic signed [imu_cal_pkg::MEAN_Z_W-1:0]   m_mean_acc_z,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_rate_x,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_rate_y,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_rate_z,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_gyro_word_x,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_gyro_word_y,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_gyro_word_z,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_accel_word_x,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_accel_word_y,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_accel_word_z
);

    import imu_cal_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    imu_cal_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_final_packet (s_final_packet),
        .status         (status),
        .cmd            (cmd)
    );

    imu_cal_dp #(
        .MAX_PACKETS (MAX_PACKETS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_acc_x        (s_acc_x),
        .s_acc_y        (s_acc_y),
        .s_acc_z        (s_acc_z),
        .s_rate_x       (s_rate_x),
        .s_rate_y       (s_rate_y),
        .s_rate_z       (s_rate_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mean_acc_x   (m_mean_acc_x),
        .m_mean_acc_y   (m_mean_acc_y),
        .m_mean_acc_z   (m_mean_acc_z),
        .m_mean_rate_x  (m_mean_rate_x),
        .m_mean_rate_y  (m_mean_rate_y),
        .m_mean_rate_z  (m_mean_rate_z),
        .m_gyro_word_x  (m_gyro_word_x),
        .m_gyro_word_y  (m_gyro_word_y),
        .m_gyro_word_z  (m_gyro_word_z),
        .m_accel_word_x (m_accel_word_x),
        .m_accel_word_y (m_accel_word_y),
        .m_accel_word_z (m_accel_word_z)
    );

    assign s_ready = cmd.in_ready;

endmodule

>>> sv/imu_cal_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_cal_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module imu_cal_div #(
    parameter int unsigned DIVIDEND_W = 22,
    parameter int unsigned DIVISOR_W  = 7
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient
);

    localparam int unsigned STEP_W = $clog2(DIVIDEND_W);

    logic                    busy_reg;
    logic                    done_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [DIVIDEND_W-1:0]   mag_reg;
    logic [DIVISOR_W-1:0]    rem_reg;
    logic                    neg_reg;

    logic [DIVIDEND_W-1:0]   abs_in;
    logic [DIVISOR_W:0]      trial;
    logic [DIVISOR_W:0]      diff;
    logic                    q_bit;
    logic [DIVISOR_W-1:0]    rem_next;

    assign abs_in = dividend[DIVIDEND_W-1] ? (DIVIDEND_W'(0) - dividend) : dividend;

    always_comb begin
        trial    = {rem_reg, mag_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, divisor};
        q_bit    = (trial >= {1'b0, divisor});
        rem_next = q_bit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVIDEND_W - 1);
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // quotient bits shift in behind the dividend bits as they leave
    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= abs_in;
            rem_reg <= '0;
            neg_reg <= dividend[DIVIDEND_W-1];
        end else if (busy_reg) begin
            mag_reg <= {mag_reg[DIVIDEND_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(DIVIDEND_W'(0) - mag_reg) : $signed(mag_reg);

endmodule

>>> sv/imu_cal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_cal_dp
// Datapath: configuration registers, per-axis sums and packet count, the
// shared divider, mean registers and the result register.
// ----------------------------------------------------------------------------
module imu_cal_dp #(
    parameter int unsigned MAX_PACKETS = imu_cal_pkg::MAX_PACKETS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  imu_cal_pkg::ctrl_cmd_t                    cmd,
    output imu_cal_pkg::dp_status_t                   status,
    input  logic                                      cfg_wr_en,
    input  logic [imu_cal_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [imu_cal_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                      s_valid,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_acc_x,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_acc_y,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_acc_z,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_rate_x,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_rate_y,
    input  logic signed [imu_cal_pkg::SAMPLE_W-1:0]   s_rate_z,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_acc_x,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_acc_y,
    output logic signed [imu_cal_pkg::MEAN_Z_W-1:0]   m_mean_acc_z,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_rate_x,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_rate_y,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_mean_rate_z,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_gyro_word_x,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_gyro_word_y,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_gyro_word_z,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_accel_word_x,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_accel_word_y,
    output logic signed [imu_cal_pkg::SAMPLE_W-1:0]   m_accel_word_z
);

    import imu_cal_pkg::*;

    localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_PACKETS);
    localparam int unsigned CNT_W = $clog2(MAX_PACKETS + 1);
    localparam int unsigned WIDE_W = MEAN_Z_W + 1;

    logic signed [SAMPLE_W-1:0] trim_reg [3];
    logic        [CFG_DATA_W-1:0] grav_reg;

    logic signed [SUM_W-1:0]    sum_reg  [NUM_LANES];
    logic        [CNT_W-1:0]    cnt_reg;
    logic signed [SAMPLE_W-1:0] mean_reg [NUM_LANES];
    logic                       m_valid_reg;

    logic signed [SAMPLE_W-1:0] sample   [NUM_LANES];
    logic                       accept;
    logic                       room;
    logic signed [SUM_W-1:0]    div_quo;
    logic                       div_done;

    logic        [MEAN_Z_W-1:0] grav_clamp;
    logic signed [WIDE_W-1:0]   acc_z_wide;
    logic signed [WIDE_W-1:0]   acc_mean_wide [3];
    logic signed [WIDE_W-1:0]   acc_eighth    [3];
    logic signed [WIDE_W-1:0]   acc_word_wide [3];
    logic signed [WIDE_W-1:0]   rate_neg      [3];
    logic signed [WIDE_W-1:0]   rate_quarter  [3];

    assign sample[0] = s_acc_x;
    assign sample[1] = s_acc_y;
    assign sample[2] = s_acc_z;
    assign sample[3] = s_rate_x;
    assign sample[4] = s_rate_y;
    assign sample[5] = s_rate_z;

    assign accept = s_valid && cmd.in_ready;
    assign room   = (cnt_reg < CNT_W'(MAX_PACKETS));

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trim_reg[0] <= '0;
            trim_reg[1] <= '0;
            trim_reg[2] <= '0;
            grav_reg    <= CFG_DATA_W'(GRAVITY_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRIM_X:  trim_reg[0] <= $signed(cfg_data);
                REG_TRIM_Y:  trim_reg[1] <= $signed(cfg_data);
                REG_TRIM_Z:  trim_reg[2] <= $signed(cfg_data);
                REG_GRAVITY: grav_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // accumulation; sums clear as the result is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int i = 0; i < NUM_LANES; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (cmd.finish) begin
            cnt_reg <= '0;
            for (int i = 0; i < NUM_LANES; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (accept && room) begin
            cnt_reg <= cnt_reg + 1'b1;
            for (int i = 0; i < NUM_LANES; i++) begin
                sum_reg[i] <= sum_reg[i] + SUM_W'(sample[i]);
            end
        end
    end

    // count is at least one here: the final beat was summed if there was room
    imu_cal_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg[cmd.lane]),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            mean_reg[cmd.lane] <= div_quo[SAMPLE_W-1:0];
        end
    end

    // result words
    always_comb begin
        grav_clamp = (grav_reg > CFG_DATA_W'(GRAVITY_MAX)) ?
                     MEAN_Z_W'(GRAVITY_MAX) : MEAN_Z_W'(grav_reg);
        if (mean_reg[2] > 0) begin
            acc_z_wide = WIDE_W'(mean_reg[2]) - $signed(WIDE_W'(grav_clamp));
        end else begin
            acc_z_wide = WIDE_W'(mean_reg[2]) + $signed(WIDE_W'(grav_clamp));
        end
        acc_mean_wide[0] = WIDE_W'(mean_reg[0]);
        acc_mean_wide[1] = WIDE_W'(mean_reg[1]);
        acc_mean_wide[2] = acc_z_wide;
        for (int i = 0; i < 3; i++) begin
            // truncating divide by 8 and by 4: bias negatives before the shift
            acc_eighth[i] = (acc_mean_wide[i] + (acc_mean_wide[i] < 0 ?
                            WIDE_W'(7) : WIDE_W'(0))) >>> 3;
            acc_word_wide[i] = WIDE_W'(trim_reg[i]) - acc_eighth[i];
            rate_neg[i] = WIDE_W'(0) - WIDE_W'(mean_reg[3 + i]);
            rate_quarter[i] = (rate_neg[i] + (rate_neg[i] < 0 ?
                              WIDE_W'(3) : WIDE_W'(0))) >>> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_mean_acc_x   <= mean_reg[0];
            m_mean_acc_y   <= mean_reg[1];
            m_mean_acc_z   <= acc_z_wide[MEAN_Z_W-1:0];
            m_mean_rate_x  <= mean_reg[3];
            m_mean_rate_y  <= mean_reg[4];
            m_mean_rate_z  <= mean_reg[5];
            m_gyro_word_x  <= rate_quarter[0][SAMPLE_W-1:0];
            m_gyro_word_y  <= rate_quarter[1][SAMPLE_W-1:0];
            m_gyro_word_z  <= rate_quarter[2][SAMPLE_W-1:0];
            m_accel_word_x <= acc_word_wide[0][SAMPLE_W-1:0];
            m_accel_word_y <= acc_word_wide[1][SAMPLE_W-1:0];
            m_accel_word_z <= acc_word_wide[2][SAMPLE_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

>>> sv/imu_cal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_cal_ctrl
// Sequencer: takes beats while idle and, after a final beat, steps the
// shared divider over the six axes, then loads the result register.
// ----------------------------------------------------------------------------
module imu_cal_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_final_packet,
    input  imu_cal_pkg::dp_status_t status,
    output imu_cal_pkg::ctrl_cmd_t  cmd
);

    import imu_cal_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [LANE_W-1:0] lane_reg, lane_next;

    always_comb begin
        state_next    = state_reg;
        lane_next     = lane_reg;
        cmd           = '0;
        cmd.lane      = lane_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_valid && s_final_packet) begin
                    lane_next  = LANE_FIRST;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    if (lane_reg == LANE_LAST) begin
                        state_next = ST_FINISH;
                    end else begin
                        lane_next  = lane_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lane_reg  <= LANE_FIRST;
        end else begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end

endmodule
